// ----- hw/rtl/detbtn_pkg.sv -----
`timescale 1ns / 1ps

package detbtn_pkg;

  // Event codes reported with every result.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CW      = 3'd1,
    EV_CCW     = 3'd2,
    EV_PRESS   = 3'd3,
    EV_RELEASE = 3'd4,
    EV_LONG    = 3'd5
  } event_e;

  // Phase pairs {a, b}: the 00 detent and the two that lead into it.
  localparam logic [1:0] PhDetent   = 2'b00;
  localparam logic [1:0] PhFromCw   = 2'b10;
  localparam logic [1:0] PhFromCcw  = 2'b01;

  localparam logic [15:0] LongPressResetMs = 16'd1000;

  typedef struct packed {
    logic        phase_a;
    logic        phase_b;
    logic        button_level;
    logic [31:0] now_ms;
    logic        clear_count;
  } in_t;

  typedef struct packed {
    event_e             event_code;
    logic signed [31:0] position;
    logic               held;
    logic [31:0]        held_ms;
  } out_t;

  // Everything one poll leaves behind for the next one.
  typedef struct packed {
    logic [1:0]  last_phases;
    logic        last_button;
    logic        button_held;
    logic        long_fired;
    logic [31:0] press_start;
    logic [31:0] detent_total;
  } state_t;

  // State after reset: the button counts as released.
  localparam state_t StateReset = '{
    last_phases:  PhDetent,
    last_button:  1'b1,
    button_held:  1'b0,
    long_fired:   1'b0,
    press_start:  32'd0,
    detent_total: 32'd0
  };

endpackage

// ----- hw/rtl/detent_encoder_and_button_events_unit.sv -----
`timescale 1ns / 1ps

// Detent quadrature encoder and push-button event unit. Each input request is
// one poll of the encoder phases A and B, the active-low button level, a
// free-running millisecond timestamp and a clear flag for the position count.
// Every poll yields exactly one result: an event code (clockwise or
// counter-clockwise step, press, release or long press; a button event wins
// over a step in the same poll), the wrapping signed position count, the held
// flag and the milliseconds elapsed since the press. A step is counted only on
// arrival at the 00 detent. The long-press time is a 16-bit register written
// through the configuration channel, which is always ready; it resets to
// 1000 ms and should be written only while no poll is in flight. Throughput is
// one poll per clock: the whole poll is evaluated combinationally between
// the state registers and the result register, so a result appears the cycle
// after its request is taken. The input side stays ready while the result
// register is empty or is being drained in the same cycle, so with a ready
// consumer requests stream at full rate.
module detent_encoder_and_button_events_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  detbtn_pkg::in_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output detbtn_pkg::out_t  out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import detbtn_pkg::*;

  state_t      st_q, st_d;
  out_t        rsp_q, rsp_d;
  logic        out_valid_q;
  logic [15:0] long_ms_q;
  logic        in_fire;

  // The result register is free when empty or when its result leaves now.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  detbtn_step u_step (
    .st_i      (st_q),
    .req_i     (in_req_i),
    .long_ms_i (long_ms_q),
    .st_o      (st_d),
    .rsp_o     (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateReset;
      out_valid_q <= 1'b0;
      long_ms_q   <= LongPressResetMs;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        long_ms_q <= cfg_data_i;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- hw/rtl/detbtn_step.sv -----
`timescale 1ns / 1ps

module detbtn_step (
  input  detbtn_pkg::state_t st_i,
  input  detbtn_pkg::in_t    req_i,
  input  logic [15:0]        long_ms_i,
  output detbtn_pkg::state_t st_o,
  output detbtn_pkg::out_t   rsp_o
);
  import detbtn_pkg::*;

  logic [1:0]  phases;
  logic [31:0] count_base;
  logic [31:0] elapsed;
  logic        btn_edge;
  event_e      ev;

  assign phases     = {req_i.phase_a, req_i.phase_b};
  assign count_base = req_i.clear_count ? 32'd0 : st_i.detent_total;
  assign elapsed    = req_i.now_ms - st_i.press_start;
  assign btn_edge   = (req_i.button_level != st_i.last_button);

  always_comb begin
    st_o              = st_i;
    st_o.last_phases  = phases;
    st_o.detent_total = count_base;
    ev                = EV_NONE;

    if (phases == PhDetent) begin
      if (st_i.last_phases == PhFromCw) begin
        st_o.detent_total = count_base + 32'd1;
        ev                = EV_CW;
      end else if (st_i.last_phases == PhFromCcw) begin
        st_o.detent_total = count_base - 32'd1;
        ev                = EV_CCW;
      end
    end

    if (btn_edge) begin
      st_o.last_button = req_i.button_level;
      st_o.long_fired  = 1'b0;
      if (!req_i.button_level) begin
        st_o.button_held = 1'b1;
        st_o.press_start = req_i.now_ms;
        ev               = EV_PRESS;
      end else begin
        st_o.button_held = 1'b0;
        ev               = EV_RELEASE;
      end
    end else if (st_i.button_held && !st_i.long_fired) begin
      if (elapsed >= {16'd0, long_ms_i}) begin
        st_o.long_fired = 1'b1;
        ev              = EV_LONG;
      end
    end

    rsp_o.event_code = ev;
    rsp_o.position   = st_o.detent_total;
    rsp_o.held       = st_o.button_held;
    // On the press poll the start equals now, so the elapsed time is zero.
    if (!st_o.button_held) begin
      rsp_o.held_ms = 32'd0;
    end else if (btn_edge) begin
      rsp_o.held_ms = 32'd0;
    end else begin
      rsp_o.held_ms = elapsed;
    end
  end

endmodule

// ----- hw/rtl/detbtn_checker.sv -----
`timescale 1ns / 1ps

module detbtn_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input detbtn_pkg::out_t out_rsp_o
);
  import detbtn_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // Every accepted request shows a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // The press duration is zero whenever the button is not held.
  a_held_ms_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.held |-> out_rsp_o.held_ms == 32'd0)
    else $error("held_ms nonzero while released");

  // A press starts the hold at zero elapsed time.
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.event_code == EV_PRESS
      |-> out_rsp_o.held && out_rsp_o.held_ms == 32'd0)
    else $error("press event with wrong hold state");

  // A release ends the hold, and a long press only happens while held.
  a_release_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.event_code == EV_RELEASE || out_rsp_o.event_code == EV_LONG)
      |-> out_rsp_o.held == (out_rsp_o.event_code == EV_LONG))
    else $error("release or long press with wrong hold state");

endmodule

bind detent_encoder_and_button_events_unit detbtn_checker u_detbtn_checker (.*);

// ----- tb/tb_detent_encoder_and_button_events_unit.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the detent encoder and button event unit. A short
// table of polls walks every event, the detent arrivals, the clear flag and
// the timestamp wrap. Random encoder walks with button activity then follow
// under several long-press settings. Every accepted request is run through a
// local model of the unit, and every result is checked field by field.
module tb_detent_encoder_and_button_events_unit;
  import detbtn_pkg::*;

  // The receiver holds off this long once, so the unit fills and stalls.
  localparam int unsigned HoldOffCycles   = 60;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned StallLimit      = 4000;
  localparam int unsigned ItemsPerSetting = 175;
  localparam int unsigned NumSettings     = 6;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t rsp;
  } poll_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  // A hand-written expectation travels with its request, so the monitor
  // can take it instead of the predicted one.
  bit          row_typed = 1'b0;
  out_t        row_rsp   = '0;

  // Mirror of the unit's state, updated once per accepted request.
  logic [1:0]  prev_phases = PhDetent;
  logic        prev_button = 1'b1;
  logic        btn_down    = 1'b0;
  logic        long_done   = 1'b0;
  logic [31:0] press_t0    = '0;
  logic [31:0] pos_count   = '0;
  logic [15:0] hold_limit  = LongPressResetMs;

  out_t        expected_q[$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  // Shared knobs: calm removes random idling on both sides, hold_req asks the
  // receiver for one long hold-off.
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;

  // Random walk state for the encoder, button and clock.
  int unsigned walk_idx  = 0;
  int          walk_dir  = 1;
  logic        walk_btn  = 1'b1;
  logic [31:0] walk_now  = '0;

  detent_encoder_and_button_events_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicts one poll. A step counts only on arrival at the detent, a clear
  // comes before the step, and a button edge replaces any step event. The
  // long-press test is skipped in the poll of an edge.
  function automatic out_t predict_poll(in_t p);
    logic [1:0]  ph;
    logic [31:0] elapsed;
    event_e      ev;
    out_t        r;
    ph = {p.phase_a, p.phase_b};
    ev = EV_NONE;
    if (p.clear_count) pos_count = '0;
    if (ph == PhDetent && prev_phases == PhFromCw) begin
      pos_count = pos_count + 32'd1;
      ev = EV_CW;
    end else if (ph == PhDetent && prev_phases == PhFromCcw) begin
      pos_count = pos_count - 32'd1;
      ev = EV_CCW;
    end
    prev_phases = ph;
    if (p.button_level != prev_button) begin
      btn_down = !p.button_level;
      if (btn_down) press_t0 = p.now_ms;
      ev = btn_down ? EV_PRESS : EV_RELEASE;
      long_done = 1'b0;
      prev_button = p.button_level;
    end else if (btn_down && !long_done) begin
      elapsed = p.now_ms - press_t0;
      if (elapsed >= {16'd0, hold_limit}) begin
        long_done = 1'b1;
        ev = EV_LONG;
      end
    end
    elapsed = p.now_ms - press_t0;
    r.event_code = ev;
    r.position   = pos_count;
    r.held       = btn_down;
    r.held_ms    = btn_down ? elapsed : 32'd0;
    return r;
  endfunction

  task automatic check_result(out_t got, out_t want);
    if (got.event_code !== want.event_code) begin
      $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
      fail_count++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      fail_count++;
    end
    if (got.held !== want.held) begin
      $error("held: expected %0b, got %0b", want.held, got.held);
      fail_count++;
    end
    if (got.held_ms !== want.held_ms) begin
      $error("held_ms: expected %0d, got %0d", want.held_ms, got.held_ms);
      fail_count++;
    end
  endtask

  // Monitor. Inputs change only by nonblocking assignment at the edge, so the
  // values seen here are the ones the unit sampled.
  always @(posedge clk_i) begin
    out_t predicted;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = predict_poll(in_req_i);
        expected_q.push_back(row_typed ? row_rsp : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          check_result(out_rsp_o, expected_q.pop_front());
        end
      end
    end
  end

  // Watchdog on the handshakes.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = draw_wait();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Offers one request and returns in the step of its acceptance. Valid is
  // left high so the next request can follow without a gap.
  task automatic offer_poll(in_t p, bit typed, out_t want);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= p;
    row_typed  <= typed;
    row_rsp    <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every result is back, then lets the
  // pipeline settle.
  task automatic drain_polls();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_hold_time(logic [15:0] ms);
    drain_polls();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ms;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    hold_limit = ms;
  endtask

  function automatic poll_row_t mk_row(bit a, bit b, bit btn, logic [31:0] now, bit clr,
                                       bit typed, event_e ev, int pos, bit held,
                                       logic [31:0] hms);
    poll_row_t r;
    r.req.phase_a      = a;
    r.req.phase_b      = b;
    r.req.button_level = btn;
    r.req.now_ms       = now;
    r.req.clear_count  = clr;
    r.typed            = typed;
    r.rsp.event_code   = ev;
    r.rsp.position     = pos;
    r.rsp.held         = held;
    r.rsp.held_ms      = hms;
    return r;
  endfunction

  // Next random poll. Mostly the phases walk the Gray sequence 00, 01, 11, 10
  // in one direction so that detent arrivals happen; sometimes they jump. The
  // clock advances in steps scaled to the long-press time, with rare jumps
  // anywhere in the 32-bit range.
  task automatic next_random_poll(output in_t p);
    logic [1:0]  gray[4];
    int unsigned k;
    int unsigned span;
    gray = '{2'b00, 2'b01, 2'b11, 2'b10};
    k = $urandom_range(0, 15);
    if ($urandom_range(0, 7) == 0) walk_dir = -walk_dir;
    if (k < 11) begin
      walk_idx = (walk_idx + 4 + walk_dir) % 4;
    end else if (k >= 13) begin
      walk_idx = $urandom_range(0, 3);
    end
    if ($urandom_range(0, 9) == 0) walk_btn = !walk_btn;
    span = hold_limit / 3 + 3;
    if ($urandom_range(0, 31) == 0) begin
      walk_now = $urandom();
    end else begin
      walk_now = walk_now + $urandom_range(0, span);
    end
    p.phase_a      = gray[walk_idx][1];
    p.phase_b      = gray[walk_idx][0];
    p.button_level = walk_btn;
    p.now_ms       = walk_now;
    p.clear_count  = ($urandom_range(0, 15) == 0);
  endtask

  initial begin
    poll_row_t   poll_table[$];
    logic [15:0] hold_set[NumSettings];
    in_t         p;
    out_t        none_rsp;

    none_rsp = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed polls under the reset long-press time of 1000 ms.
    poll_table.push_back(mk_row(0, 0, 1, 32'd0, 0, 1, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(1, 0, 1, 32'd5, 0, 1, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd6, 0, 1, EV_CW, 1, 0, 0));
    poll_table.push_back(mk_row(0, 1, 1, 32'd7, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd8, 0, 1, EV_CCW, 0, 0, 0));
    // Arrival at the detent from 11 counts nothing.
    poll_table.push_back(mk_row(1, 1, 1, 32'd9, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd10, 0, 1, EV_NONE, 0, 0, 0));
    // Stepping down from zero wraps to minus one.
    poll_table.push_back(mk_row(0, 1, 1, 32'd11, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd12, 0, 1, EV_CCW, -1, 0, 0));
    // Clear alone, then clear together with a step: zeroed first, then counted.
    poll_table.push_back(mk_row(1, 0, 1, 32'd13, 1, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd14, 1, 1, EV_CW, 1, 0, 0));
    // Press just before the timestamp wraps; the long press fires across it.
    poll_table.push_back(mk_row(1, 1, 0, 32'hFFFF_FFF0, 0, 1, EV_PRESS, 1, 1, 0));
    poll_table.push_back(mk_row(1, 1, 0, 32'h0000_0010, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 0, 32'd984, 0, 1, EV_LONG, 1, 1, 1000));
    poll_table.push_back(mk_row(1, 0, 0, 32'd2000, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 0, 32'd2001, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(1, 0, 1, 32'd2002, 0, 1, EV_RELEASE, 2, 0, 0));
    // A press in the same poll as a step reports the press.
    poll_table.push_back(mk_row(0, 0, 0, 32'd2003, 0, 1, EV_PRESS, 3, 1, 0));
    poll_table.push_back(mk_row(0, 0, 1, 32'd2004, 0, 0, EV_NONE, 0, 0, 0));
    // Press at the top timestamp; one ms short, then exactly on time.
    poll_table.push_back(mk_row(0, 0, 0, 32'hFFFF_FFFF, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 0, 32'd998, 0, 0, EV_NONE, 0, 0, 0));
    poll_table.push_back(mk_row(0, 0, 0, 32'd999, 0, 1, EV_LONG, 3, 1, 1000));
    poll_table.push_back(mk_row(0, 0, 1, 32'd0, 0, 0, EV_NONE, 0, 0, 0));

    foreach (poll_table[i]) begin
      offer_poll(poll_table[i].req, poll_table[i].typed, poll_table[i].rsp);
    end

    // Random part. The settings cover zero, one, the largest value, two random
    // long-press times and a fixed 7 ms one.
    hold_set[0] = 16'd0;
    hold_set[1] = 16'd1;
    hold_set[2] = 16'hFFFF;
    hold_set[3] = 16'($urandom_range(2, 200));
    hold_set[4] = 16'($urandom_range(0, 65535));
    hold_set[5] = 16'd7;
    walk_btn = prev_button;
    walk_now = $urandom();

    for (int s = 0; s < NumSettings; s++) begin
      write_hold_time(hold_set[s]);
      for (int n = 0; n < ItemsPerSetting; n++) begin
        // A calm stretch at the start of every setting.
        calm = (n < 30);
        // Once, the receiver stalls for long while requests keep coming.
        if (s == 1 && n == 0) hold_req = 1'b1;
        // Once, the sender pauses until every result is back.
        if (s == 3 && n == 90) drain_polls();
        next_random_poll(p);
        offer_poll(p, 1'b0, none_rsp);
      end
    end
    calm = 1'b0;

    drain_polls();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
